FILE: hdl/sta_pkg.sv
package sta_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = 4;

  // Angles are kept in a 26-bit signed Q.16 word for the reduction path.
  localparam int ANG_W = 26;
  localparam logic signed [ANG_W-1:0] Q_TWO_PI  = 26'sd411775;
  localparam logic signed [ANG_W-1:0] Q_PI      = 26'sd205887;
  localparam logic signed [ANG_W-1:0] Q_HALF_PI = 26'sd102944;

  // CORDIC datapath width: the Q.30 vector stays below 2^31 in magnitude.
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Radius times a Q.30 trig value: 24-bit by 32-bit signed product.
  localparam int PROD_W = 56;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 56'sd536870912;

  localparam logic [22:0] LIMIT_RESET = 23'd3932160;
  localparam logic [1:0] ADDR_LIMIT = 2'd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OFFSET,
    S_REDUCE,
    S_FOLD,
    S_ROT,
    S_MUL_X,
    S_MUL_Y,
    S_PLATE,
    S_VEC,
    S_CMP,
    S_DONE
  } state_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      4'd0: r = 26'sd51472;
      4'd1: r = 26'sd30386;
      4'd2: r = 26'sd16055;
      4'd3: r = 26'sd8150;
      4'd4: r = 26'sd4091;
      4'd5: r = 26'sd2047;
      4'd6: r = 26'sd1024;
      4'd7: r = 26'sd512;
      4'd8: r = 26'sd256;
      4'd9: r = 26'sd128;
      4'd10: r = 26'sd64;
      4'd11: r = 26'sd32;
      4'd12: r = 26'sd16;
      4'd13: r = 26'sd8;
      4'd14: r = 26'sd4;
      default: r = 26'sd2;
    endcase
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [CW+1:0] v);
    if (v > 36'sd8388607) return 24'sh7FFFFF;
    if (v < -36'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

FILE: hdl/spinning_target_aim_point.sv
// Channel   | Direction | Contents
// s_axis    | in        | target estimate request (tdata, see port comment)
// m_axis    | out       | aim point request (tdata, tuser = spin_mode)
// APB       | in/out    | register 0: yaw_rate_limit
//
// Each plate passes through an offset state, a reduction state that removes
// one full turn at a time (up to 21 turns), a fold state, 16 rotation steps,
// two multiply states and a plate state, and in spin mode 16 vectoring
// steps and a compare. Normal mode evaluates only plate 0; spin mode
// evaluates up to MAX_PLATES. A done state follows, after which the block
// returns to idle.
// Reset is synchronous and returns the limit register to 60.0 rad/s.
// The result sits in an output register until taken, so a new request can
// be accepted meanwhile; only the done cycle waits on an unclaimed result.
module spinning_target_aim_point #(
  parameter int MAX_PLATES = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // center_x[23:0], center_y[47:24], center_z[71:48], body_yaw[95:72],
  // radius[118:96], height_offset[142:119], yaw_rate[166:143],
  // armor_count[169:167], zero fill above
  input  logic [175:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // aim_x[23:0], aim_y[47:24], aim_z[71:48], chosen_plate[73:72], zero fill
  output logic [79:0]  m_tdata,
  // spin_mode
  output logic         m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import sta_pkg::*;

  localparam int PW = $clog2(MAX_PLATES + 1);

  logic [22:0] yaw_rate_limit;

  // Configuration port: one register at address zero.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LIMIT) ? {9'd0, yaw_rate_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_rate_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_LIMIT) begin
      yaw_rate_limit <= pwdata[22:0];
    end
  end

  state_t state, state_next;

  // Captured request.
  logic signed [23:0] cx, cy, cz, yaw, hoff;
  logic [22:0] rad;
  logic [PW-1:0] count;
  logic spin;

  // Working registers.
  logic [PW-1:0] plate_i;
  logic [STEP_W-1:0] step;
  logic signed [CW-1:0] vx, vy;
  logic signed [ANG_W-1:0] ang;
  logic neg;
  logic signed [PROD_W-1:0] prod;
  logic signed [23:0] px, py, pz;
  logic signed [23:0] bx, by, bz;
  logic signed [ANG_W-1:0] bestd;
  logic [PW-1:0] pick;

  // Output register.
  logic signed [23:0] out_x, out_y, out_z;
  logic [1:0] out_plate;
  logic out_spin;
  logic out_load;

  logic signed [CW-1:0] cx_next, cy_next;
  logic signed [ANG_W-1:0] ca_next;

  sta_cordic u_cordic (
    .vectoring (state == S_VEC),
    .step      (step),
    .x         (vx),
    .y         (vy),
    .ang       (ang),
    .x_next    (cx_next),
    .y_next    (cy_next),
    .ang_next  (ca_next)
  );

  // Input decode.
  logic signed [23:0] in_rate;
  logic [23:0] in_abs_rate;
  logic [2:0] in_cnt;
  logic [PW-1:0] in_n;
  always_comb begin
    in_rate = s_tdata[166:143];
    in_abs_rate = in_rate[23] ? 24'(-in_rate) : in_rate;
    in_cnt = s_tdata[169:167];
    if (in_cnt == 3'd0) in_n = PW'(1);
    else if (32'(in_cnt) > MAX_PLATES) in_n = PW'(MAX_PLATES);
    else in_n = PW'(in_cnt);
  end

  // Plate offset (i*2pi)/n comes from a constant table over plate count and
  // plate index, picked by the captured count and the current plate.
  logic signed [ANG_W-1:0] off_tab [MAX_PLATES][MAX_PLATES];
  for (genvar k = 1; k <= MAX_PLATES; k++) begin : g_cnt
    for (genvar j = 0; j < MAX_PLATES; j++) begin : g_plate
      localparam logic signed [ANG_W-1:0] OFF = ANG_W'((j * int'(Q_TWO_PI)) / k);
      assign off_tab[k-1][j] = OFF;
    end
  end

  logic signed [ANG_W-1:0] offset;
  always_comb begin
    offset = '0;
    for (int k = 1; k <= MAX_PLATES; k++) begin
      for (int j = 0; j < MAX_PLATES; j++) begin
        if (32'(count) == k && 32'(plate_i) == j)
          offset = off_tab[k-1][j];
      end
    end
  end

  // Angle reduction into (-pi, pi] by compare and subtract, one turn per
  // cycle; the sum of a 24-bit yaw and a plate offset lies within about
  // twenty-one turns.
  logic signed [ANG_W-1:0] red;
  always_comb begin
    red = ang;
    if (red > Q_PI) red = red - Q_TWO_PI;
    else if (red <= -Q_PI) red = red + Q_TWO_PI;
  end

  logic signed [CW-1:0] trig_c, trig_s;
  assign trig_c = neg ? -vx : vx;
  assign trig_s = neg ? -vy : vy;

  // One multiplier serves both the x and the y product.
  logic signed [23:0] mul_a;
  logic signed [31:0] mul_b;
  assign mul_a = $signed({1'b0, rad});
  assign mul_b = (state == S_MUL_X) ? trig_c[31:0] : trig_s[31:0];

  logic signed [PROD_W-1:0] rounded;
  assign rounded = (prod + ROUND_HALF) >>> 30;

  logic signed [ANG_W-1:0] d_abs;
  always_comb begin
    logic signed [ANG_W-1:0] dd;
    dd = (pz >= 0) ? ang : Q_PI - ang;
    d_abs = dd < 0 ? -dd : dd;
  end

  // Magnitudes for the vectoring start; pz is formed in the same cycle.
  logic signed [CW-1:0] pz_next_abs, px_abs;
  always_comb begin
    logic signed [24:0] zz;
    zz = plate_i[0] ? 25'(cz) - 25'(hoff) : 25'(cz) + 25'(hoff);
    if (zz > 25'sd8388607) zz = 25'sd8388607;
    if (zz < -25'sd8388608) zz = -25'sd8388608;
    pz_next_abs = zz < 0 ? -CW'(zz) : CW'(zz);
    px_abs = px < 0 ? -CW'(px) : CW'(px);
  end

  // The done cycle hands the result over once the output register is free.
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_OFFSET;
      S_OFFSET: state_next = S_REDUCE;
      S_REDUCE: state_next = (red == ang) ? S_FOLD : S_REDUCE;
      S_FOLD:   state_next = S_ROT;
      S_ROT:    if (step == STEP_W'(CORDIC_STEPS - 1)) state_next = S_MUL_X;
      S_MUL_X:  state_next = S_MUL_Y;
      S_MUL_Y:  state_next = S_PLATE;
      S_PLATE:  state_next = spin ? S_VEC : S_DONE;
      S_VEC:    if (step == STEP_W'(CORDIC_STEPS - 1)) state_next = S_CMP;
      S_CMP:    state_next = (plate_i + PW'(1) < count) ? S_OFFSET : S_DONE;
      S_DONE:   if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cx <= s_tdata[23:0];
          cy <= s_tdata[47:24];
          cz <= s_tdata[71:48];
          yaw <= s_tdata[95:72];
          rad <= s_tdata[118:96];
          hoff <= s_tdata[142:119];
          count <= in_n;
          spin <= {1'b0, in_abs_rate} > {2'b0, yaw_rate_limit};
          plate_i <= '0;
          pick <= '0;
        end
      end
      S_OFFSET: begin
        ang <= ANG_W'(yaw) + offset;
      end
      S_REDUCE: begin
        ang <= red;
      end
      S_FOLD: begin
        // Fold into [-pi/2, pi/2]; the result's signs flip afterwards.
        neg <= 1'b0;
        if (ang > Q_HALF_PI) begin
          ang <= ang - Q_PI; neg <= 1'b1;
        end else if (ang < -Q_HALF_PI) begin
          ang <= ang + Q_PI; neg <= 1'b1;
        end
        vx <= CORDIC_GAIN;
        vy <= '0;
        step <= '0;
      end
      S_ROT: begin
        vx <= cx_next; vy <= cy_next; ang <= ca_next;
        step <= step + STEP_W'(1);
      end
      S_MUL_X: begin
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      S_MUL_Y: begin
        px <= sat24((CW+2)'(cx) - (CW+2)'(rounded));
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      S_PLATE: begin
        py <= sat24((CW+2)'(cy) - (CW+2)'(rounded));
        if (plate_i[0]) pz <= sat24((CW+2)'(cz) - (CW+2)'(hoff));
        else pz <= sat24((CW+2)'(cz) + (CW+2)'(hoff));
        if (plate_i == '0) begin
          bx <= px;
        end
        // Vectoring input: |z|*64 and |x|*64.
        step <= '0;
        ang <= '0;
      end
      S_VEC: begin
        if (step == '0) begin
          // First step uses freshly formed magnitudes.
          vx <= cx_next; vy <= cy_next; ang <= ca_next;
        end else begin
          vx <= cx_next; vy <= cy_next; ang <= ca_next;
        end
        step <= step + STEP_W'(1);
      end
      S_CMP: begin
        if (plate_i == '0 || d_abs < bestd) begin
          bestd <= d_abs; pick <= plate_i;
          bx <= px; by <= py; bz <= pz;
        end
        plate_i <= plate_i + PW'(1);
      end
      S_DONE: begin
        // Normal mode takes plate 0 as it stands.
        if (out_load) begin
          out_x <= spin ? bx : px;
          out_y <= spin ? by : py;
          out_z <= spin ? bz : pz;
          out_plate <= 2'(pick);
          out_spin <= spin;
        end
      end
      default: ;
    endcase
    if (state == S_PLATE) begin
      vx <= (pz_next_abs <<< 6);
      vy <= (px_abs <<< 6);
    end
  end

  assign m_tdata = {6'd0, out_plate, out_z, out_y, out_x};
  assign m_tuser = out_spin;

endmodule

FILE: hdl/sta_cordic.sv
// Shared CORDIC micro-rotation: one step of either rotation or vectoring.
module sta_cordic (
  input  logic                         vectoring,
  input  logic [sta_pkg::STEP_W-1:0]   step,
  input  logic signed [sta_pkg::CW-1:0]    x,
  input  logic signed [sta_pkg::CW-1:0]    y,
  input  logic signed [sta_pkg::ANG_W-1:0] ang,
  output logic signed [sta_pkg::CW-1:0]    x_next,
  output logic signed [sta_pkg::CW-1:0]    y_next,
  output logic signed [sta_pkg::ANG_W-1:0] ang_next
);
  import sta_pkg::*;

  logic dir;
  logic signed [CW-1:0] xs, ys;

  always_comb begin
    xs = x >>> step;
    ys = y >>> step;
    // Rotation drives the angle to zero; vectoring drives y to zero.
    dir = vectoring ? (y > 0) : (ang >= 0);
    if (vectoring) begin
      if (dir) begin
        x_next = x + ys; y_next = y - xs; ang_next = ang + atan_entry(step);
      end else begin
        x_next = x - ys; y_next = y + xs; ang_next = ang - atan_entry(step);
      end
    end else begin
      if (dir) begin
        x_next = x - ys; y_next = y + xs; ang_next = ang - atan_entry(step);
      end else begin
        x_next = x + ys; y_next = y - xs; ang_next = ang + atan_entry(step);
      end
    end
  end
endmodule

FILE: bench/aim_point_checker.sv
`timescale 1ns / 100ps

module aim_point_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [175:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [79:0]  m_tdata,
  input  logic         m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               spin;
    logic [1:0]         plate;
  } aim_t;

  localparam longint TWO_PI = 411775;
  localparam longint PI_Q = 205887;
  localparam longint HALF_PI = 102944;

  aim_t aim_queue[$];
  logic [22:0] rate_limit;

  function automatic longint arctan_step(input int i);
    longint tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2};
    return tab[i];
  endfunction

  function automatic longint clip24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Rotation CORDIC after folding the angle into [-pi/2, pi/2].
  function automatic void rotate(input longint ang, output longint c, output longint s);
    longint r, x, y, nx;
    bit flip;
    r = ang % TWO_PI;
    flip = 0;
    x = 652032874;
    y = 0;
    if (r < 0) r += TWO_PI;
    if (r > PI_Q) r -= TWO_PI;
    if (r > HALF_PI) begin
      r -= PI_Q;
      flip = 1;
    end else if (r < -HALF_PI) begin
      r += PI_Q;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); r -= arctan_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); r += arctan_step(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint view_angle(input longint x, input longint z);
    longint a, b, ang, na;
    a = (z < 0 ? -z : z) * 64;
    b = (x < 0 ? -x : x) * 64;
    ang = 0;
    for (int i = 0; i < 16; i++) begin
      if (b > 0) begin
        na = a + (b >>> i); b = b - (a >>> i); ang += arctan_step(i);
      end else begin
        na = a - (b >>> i); b = b + (a >>> i); ang -= arctan_step(i);
      end
      a = na;
    end
    return z >= 0 ? ang : PI_Q - ang;
  endfunction

  function automatic void plate_position(input logic [175:0] d, input longint off,
                                         input bit odd, output longint px,
                                         output longint py, output longint pz);
    longint c, s, r, h;
    r = longint'(d[118:96]);
    h = longint'($signed(d[142:119]));
    rotate(longint'($signed(d[95:72])) + off, c, s);
    px = clip24(longint'($signed(d[23:0])) - ((r * c + (64'sd1 <<< 29)) >>> 30));
    py = clip24(longint'($signed(d[47:24])) - ((r * s + (64'sd1 <<< 29)) >>> 30));
    pz = clip24(odd ? longint'($signed(d[71:48])) - h : longint'($signed(d[71:48])) + h);
  endfunction

  function automatic aim_t predict_aim(input logic [175:0] d);
    aim_t a;
    longint rate, bx, by, bz, px, py, pz, bd, dd;
    int n, pick;
    rate = longint'($signed(d[166:143]));
    if (rate < 0) rate = -rate;
    n = d[169:167];
    if (n == 0) n = 1;
    if (n > 4) n = 4;
    pick = 0;
    plate_position(d, 0, 0, bx, by, bz);
    a.spin = rate > longint'(rate_limit);
    if (a.spin) begin
      bd = view_angle(bx, bz);
      if (bd < 0) bd = -bd;
      for (int i = 1; i < n; i++) begin
        plate_position(d, (i * TWO_PI) / n, i[0], px, py, pz);
        dd = view_angle(px, pz);
        if (dd < 0) dd = -dd;
        if (dd < bd) begin
          bd = dd; pick = i; bx = px; by = py; bz = pz;
        end
      end
    end
    a.x = bx[23:0];
    a.y = by[23:0];
    a.z = bz[23:0];
    a.plate = pick[1:0];
    return a;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    aim_t want, got;
    if (rst) begin
      rate_limit <= sta_pkg::LIMIT_RESET;
      fail_count = 0;
      aim_queue.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == sta_pkg::ADDR_LIMIT[1:0])
        rate_limit <= pwdata[22:0];
      if (s_tvalid && s_tready)
        aim_queue.push_back(predict_aim(s_tdata));
      if (m_tvalid && m_tready) begin
        got.x = m_tdata[23:0];
        got.y = m_tdata[47:24];
        got.z = m_tdata[71:48];
        got.plate = m_tdata[73:72];
        got.spin = m_tuser;
        if (aim_queue.size() == 0) begin
          report("unexpected aim point", 1, 0);
        end else begin
          want = aim_queue.pop_front();
          if (got.x !== want.x) report("aim_x", got.x, want.x);
          if (got.y !== want.y) report("aim_y", got.y, want.y);
          if (got.z !== want.z) report("aim_z", got.z, want.z);
          if (got.spin !== want.spin) report("spin_mode", got.spin, want.spin);
          if (got.plate !== want.plate) report("chosen_plate", got.plate, want.plate);
        end
      end
      pending <= aim_queue.size();
    end
  end

endmodule

FILE: bench/tb_spinning_target_aim_point.sv
`timescale 1ns / 100ps

module tb_spinning_target_aim_point;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // center_x, center_y, center_z, body_yaw, radius, height_offset, yaw_rate, armor_count
  logic [175:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // aim_x, aim_y, aim_z, chosen_plate
  logic [79:0]  m_tdata;
  // spin_mode
  logic         m_tuser;
  logic         psel, penable, pwrite, pready;
  logic [1:0]   paddr;
  logic [31:0]  pwdata, prdata;
  int           fail_count, pending;
  int           cycle_count;
  bit           hold_sink;

  spinning_target_aim_point dut (.*);

  aim_point_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up well beyond the slowest legal run: four plates at extreme yaw for
  // every request, plus idle gaps on both sides and the long sink stall.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The sink draws a random stall per request. While hold_sink is set it
  // refuses everything, which backs the block up and stalls its input.
  initial begin
    int gap;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        m_tready <= 1'b0;
      end else if (m_tready && !m_tvalid) begin
        // Keep ready up until a request actually moves.
      end else begin
        gap = $urandom_range(0, 5);
        if ((m_tready && m_tvalid) || !m_tready) begin
          if (gap == 0 || $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b1;
          end else begin
            m_tready <= 1'b0;
            repeat (gap - 1) @(posedge clk);
            if (!hold_sink) m_tready <= 1'b1;
          end
        end
      end
    end
  end

  task automatic write_limit(input logic [22:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= sta_pkg::ADDR_LIMIT[1:0]; pwdata <= {9'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Stop offering, wait for every expected aim point, then let the block settle.
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // One request, with a random number of idle cycles in front of it when spread
  // is set. Valid stays up after the accept so that back-to-back requests need no gap.
  task automatic send_target(input logic [175:0] d, input bit spread);
    int gap;
    gap = spread ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [175:0] pack_target(
      input logic [23:0] cx, input logic [23:0] cy, input logic [23:0] cz,
      input logic [23:0] yaw, input logic [22:0] r, input logic [23:0] h,
      input logic [23:0] rate, input logic [2:0] n);
    return {6'd0, n, rate, h, r, yaw, cz, cy, cx};
  endfunction

  // Mostly plausible targets a few metres away with small radii, some wide noise.
  function automatic logic [175:0] random_target(input bit realistic);
    logic [23:0] cx, cy, cz, yaw, h, rate;
    logic [22:0] r;
    if (realistic) begin
      cx = 24'($urandom_range(0, 1 << 20) - (1 << 19));
      cy = 24'($urandom_range(0, 1 << 20) - (1 << 19));
      cz = 24'($urandom_range(0, 1 << 20));
      yaw = 24'($urandom_range(0, 1 << 20) - (1 << 19));
      r = 23'($urandom_range(0, 1 << 16));
      h = 24'($urandom_range(0, 1 << 14) - (1 << 13));
      rate = 24'($urandom_range(0, 1 << 23) - (1 << 22));
    end else begin
      cx = 24'($urandom); cy = 24'($urandom); cz = 24'($urandom);
      yaw = 24'($urandom); r = 23'($urandom); h = 24'($urandom);
      rate = 24'($urandom);
    end
    return pack_target(cx, cy, cz, yaw, r, h, rate, 3'($urandom_range(0, 7)));
  endfunction

  initial begin
    logic [22:0] limits[4] = '{23'd0, 23'h7FFFFF, 23'd65536, 23'd3932160};
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cycle_count = 0;
    hold_sink = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, both modes, all plate counts including zero
    // and counts above the plate limit, and yaw angles that need folding.
    send_target(pack_target(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                            23'h7FFFFF, 24'h7FFFFF, 24'h000000, 3'd0), 1);
    send_target(pack_target(24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000,
                            23'h7FFFFF, 24'h800000, 24'h800000, 3'd7), 1);
    send_target(pack_target('0, '0, '0, '0, '0, '0, 24'h7FFFFF, 3'd0), 1);
    send_target(pack_target('0, '0, '0, '0, '0, '0, 24'h3C0000, 3'd4), 1);
    send_target(pack_target('0, '0, 24'd196608, '0, 23'd16384, '0, 24'h3C0001, 3'd4), 1);
    for (int n = 0; n < 8; n++)
      send_target(pack_target(24'd65536, 24'd0, 24'd327680, 24'(205887 + n * 51472),
                              23'd16384, 24'd6554, 24'hC00000, n[2:0]), 1);
    send_target(pack_target('0, '0, 24'hFD0000, 24'hFCDC41, 23'd20000, 24'd3000,
                            24'h500000, 3'd2), 1);
    drain();

    // Several limit settings, each followed by random requests.
    for (int phase = 0; phase < 4; phase++) begin
      write_limit(limits[phase]);
      for (int k = 0; k < 230; k++) begin
        if (phase == 1 && k == 100) begin
          // Long sink stall while requests keep coming.
          hold_sink = 1'b1;
          fork
            begin
              repeat (1500) @(posedge clk);
              hold_sink = 1'b0;
            end
          join_none
        end
        if (phase == 2 && k == 120) drain();
        send_target(random_target($urandom_range(0, 9) != 0), $urandom_range(0, 3) != 0);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/sta_pkg.sv
hdl/sta_cordic.sv
hdl/spinning_target_aim_point.sv
bench/aim_point_checker.sv
bench/tb_spinning_target_aim_point.sv
